[src/two_class_priority_queue_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the two-class priority queue.
// Each check is clocked on clk and held off while rst is high.
// ---------------------------------------------------------------------------
`ifndef TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS

// expr must hold at every clock edge
`define TCPQ_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("tcpq: invariant violated");

// cons must hold in the cycle after ante
`define TCPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcpq: sequence violated");

`else

`define TCPQ_ASSERT_ALWAYS(label, expr)
`define TCPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[src/tcpq_pkg.sv]
// ---------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants of the two-class priority queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcpq_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic signed [VALUE_W-1:0] THRESHOLD_RESET = 32'sd60;

  // request opcodes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // response status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

[src/tcpq_cfg_if.sv]
// ---------------------------------------------------------------------------
// tcpq_cfg_if
// Configuration write channel: threshold register data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcpq_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [tcpq_pkg::VALUE_W-1:0]      data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/tcpq_req_if.sv]
// ---------------------------------------------------------------------------
// tcpq_req_if
// Request channel: enqueue or dequeue with a signed value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcpq_req_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     operation;
  logic signed [tcpq_pkg::VALUE_W-1:0]      item_value;

  modport source (output valid, output operation, output item_value, input ready);
  modport sink   (input valid, input operation, input item_value, output ready);
endinterface

`default_nettype wire

[src/tcpq_rsp_if.sv]
// ---------------------------------------------------------------------------
// tcpq_rsp_if
// Response channel: status, dequeued value and class fill counts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcpq_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic [tcpq_pkg::STATUS_W-1:0]            status;
  logic signed [tcpq_pkg::VALUE_W-1:0]      out_value;
  logic                                     from_priority;
  logic [tcpq_pkg::COUNT_W-1:0]             priority_count;
  logic [tcpq_pkg::COUNT_W-1:0]             normal_count;

  modport source (output valid, output status, output out_value, output from_priority,
                  output priority_count, output normal_count, input ready);
  modport sink   (input valid, input status, input out_value, input from_priority,
                  input priority_count, input normal_count, output ready);
endinterface

`default_nettype wire

[src/tcpq_ram.sv]
// ---------------------------------------------------------------------------
// tcpq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcpq_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read returns the contents before a same-edge write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/two_class_priority_queue.sv]
// ---------------------------------------------------------------------------
// two_class_priority_queue
// Strict-priority queue with two FIFO classes split by a signed threshold.
// ---------------------------------------------------------------------------
//  channel  dir   beat contents
//  cfg      in    data: priority threshold (signed 32)
//  req      in    operation, item_value
//  rsp      out   status, out_value, from_priority, priority_count, normal_count
//
//  Enqueue and empty dequeue: response registered, back-to-back requests accepted.
//  Successful dequeue: goes through the registered read of the class RAM
//  (pointer update on accept, data captured in the next cycle).
//  req is held off during the RAM read, and while a response waits and rsp.ready is low.
//  Reset clears pointers and fills and sets the threshold to 60; RAM contents need none.
//  cfg is always ready; write it only while the queue is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "two_class_priority_queue_macros.svh"

module two_class_priority_queue #(
  parameter int unsigned CLASS_DEPTH = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  tcpq_cfg_if.sink  cfg,
  tcpq_req_if.sink  req,
  tcpq_rsp_if.source rsp
);

  localparam int unsigned PTR_W  = $clog2(CLASS_DEPTH);
  localparam int unsigned FILL_W = $clog2(CLASS_DEPTH + 1);
  localparam int unsigned VW     = tcpq_pkg::VALUE_W;
  localparam int unsigned CW     = tcpq_pkg::COUNT_W;

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(CLASS_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CLASS_DEPTH);

  tcpq_pkg::state_t state, state_next;

  logic signed [VW-1:0] threshold;

  logic [PTR_W-1:0]  prd_ptr, pwr_ptr, nrd_ptr, nwr_ptr;
  logic [FILL_W-1:0] pfill, nfill, pfill_next, nfill_next;
  logic              deq_prio;

  logic [VW-1:0] p_rdata, n_rdata;

  logic                       rsp_valid;
  logic [tcpq_pkg::STATUS_W-1:0] rsp_status;
  logic signed [VW-1:0]       rsp_value;
  logic                       rsp_prio;
  logic [CW-1:0]              rsp_pcount, rsp_ncount;

  logic in_ready, capture_read;
  logic in_acc, is_enq, enq_prio, p_full, n_full, p_empty, n_empty;
  logic p_wr, n_wr, p_rd, n_rd, deq_hit, enq_drop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // ---- configuration ----
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= tcpq_pkg::THRESHOLD_RESET;
    end else if (cfg.valid && cfg.ready) begin
      threshold <= cfg.data;
    end
  end

  // ---- request decode ----
  assign in_acc   = req.valid && in_ready;
  assign is_enq   = (req.operation == tcpq_pkg::OP_ENQ);
  assign enq_prio = (req.item_value >= threshold);
  assign p_full   = (pfill == FILL_MAX);
  assign n_full   = (nfill == FILL_MAX);
  assign p_empty  = (pfill == '0);
  assign n_empty  = (nfill == '0);

  assign p_wr     = in_acc && is_enq && enq_prio && !p_full;
  assign n_wr     = in_acc && is_enq && !enq_prio && !n_full;
  assign p_rd     = in_acc && !is_enq && !p_empty;
  assign n_rd     = in_acc && !is_enq && p_empty && !n_empty;
  assign deq_hit  = p_rd || n_rd;
  assign enq_drop = is_enq && (enq_prio ? p_full : n_full);

  always_comb begin
    pfill_next = pfill;
    nfill_next = nfill;
    if (p_wr) pfill_next = pfill + 1'b1;
    if (p_rd) pfill_next = pfill - 1'b1;
    if (n_wr) nfill_next = nfill + 1'b1;
    if (n_rd) nfill_next = nfill - 1'b1;
  end

  // ---- ring pointers and fills ----
  always_ff @(posedge clk) begin
    if (rst) begin
      prd_ptr <= '0;
      pwr_ptr <= '0;
      nrd_ptr <= '0;
      nwr_ptr <= '0;
      pfill   <= '0;
      nfill   <= '0;
    end else begin
      if (p_wr) pwr_ptr <= ptr_inc(pwr_ptr);
      if (n_wr) nwr_ptr <= ptr_inc(nwr_ptr);
      if (p_rd) prd_ptr <= ptr_inc(prd_ptr);
      if (n_rd) nrd_ptr <= ptr_inc(nrd_ptr);
      pfill <= pfill_next;
      nfill <= nfill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      deq_prio <= p_rd;
    end
  end

  // ---- class stores ----
  tcpq_ram #(.DEPTH(CLASS_DEPTH), .DATA_W(VW)) u_prio_ram (
    .clk     (clk),
    .wr_en   (p_wr),
    .wr_addr (pwr_ptr),
    .wr_data (req.item_value),
    .rd_en   (p_rd),
    .rd_addr (prd_ptr),
    .rd_data (p_rdata)
  );

  tcpq_ram #(.DEPTH(CLASS_DEPTH), .DATA_W(VW)) u_norm_ram (
    .clk     (clk),
    .wr_en   (n_wr),
    .wr_addr (nwr_ptr),
    .wr_data (req.item_value),
    .rd_en   (n_rd),
    .rd_addr (nrd_ptr),
    .rd_data (n_rdata)
  );

  // ---- control FSM ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcpq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tcpq_pkg::ST_IDLE: begin
        if (deq_hit) state_next = tcpq_pkg::ST_READ;
      end
      tcpq_pkg::ST_READ: begin
        state_next = tcpq_pkg::ST_IDLE;
      end
      default: state_next = tcpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    capture_read = 1'b0;
    unique case (state)
      tcpq_pkg::ST_IDLE: begin
        in_ready = !rsp_valid || rsp.ready;
      end
      tcpq_pkg::ST_READ: begin
        capture_read = 1'b1;
      end
      default: begin
        in_ready     = 1'b0;
        capture_read = 1'b0;
      end
    endcase
  end

  assign req.ready = in_ready;

  // ---- response register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (capture_read || (in_acc && !deq_hit)) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture_read) begin
      rsp_status <= tcpq_pkg::STATUS_OK;
      rsp_value  <= deq_prio ? p_rdata : n_rdata;
      rsp_prio   <= deq_prio;
      rsp_pcount <= CW'(pfill);
      rsp_ncount <= CW'(nfill);
    end else if (in_acc && !deq_hit) begin
      // enqueue (stored or dropped) or dequeue with both classes empty
      if (is_enq) begin
        rsp_status <= enq_drop ? tcpq_pkg::STATUS_FULL : tcpq_pkg::STATUS_OK;
        rsp_prio   <= enq_prio;
      end else begin
        rsp_status <= tcpq_pkg::STATUS_EMPTY;
        rsp_prio   <= 1'b0;
      end
      rsp_value  <= '0;
      rsp_pcount <= CW'(pfill_next);
      rsp_ncount <= CW'(nfill_next);
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.out_value      = rsp_value;
  assign rsp.from_priority  = rsp_prio;
  assign rsp.priority_count = rsp_pcount;
  assign rsp.normal_count   = rsp_ncount;

  // ---- checks ----
  `TCPQ_ASSERT_ALWAYS(a_fill_bound, (pfill <= FILL_MAX) && (nfill <= FILL_MAX))
  `TCPQ_ASSERT_ALWAYS(a_prio_empty_ptrs, (pfill != '0) || (prd_ptr == pwr_ptr))
  `TCPQ_ASSERT_ALWAYS(a_norm_empty_ptrs, (nfill != '0) || (nrd_ptr == nwr_ptr))
  `TCPQ_ASSERT_ALWAYS(a_read_slot_free, (state != tcpq_pkg::ST_READ) || !rsp_valid)
  `TCPQ_ASSERT_NEXT(a_deq_to_read, deq_hit, (state == tcpq_pkg::ST_READ))
  `TCPQ_ASSERT_NEXT(a_read_delivers, (state == tcpq_pkg::ST_READ),
                    (state == tcpq_pkg::ST_IDLE) && rsp_valid)

endmodule

`default_nettype wire
